### rtl/blrg_pkg.sv
// ----------------------------------------------------------------------------
// blrg_pkg
// Shared constants, opcodes and control/status types of the ramp generator.
// ----------------------------------------------------------------------------
package blrg_pkg;

    // Samples emitted per tick
    localparam int BLOCK_LEN = 32;

    function automatic int floor_log2(input int n);
        int v;
        int s;
        v = n;
        s = 0;
        while (v > 1) begin
            v = v >> 1;
            s = s + 1;
        end
        return s;
    endfunction

    localparam int BLOCK_SHIFT = floor_log2(BLOCK_LEN);

    // Magnitude of the level difference is 33 bits: one quotient bit per step
    localparam int DIV_STEPS = 33;
    localparam int CNT_MAX   = (DIV_STEPS > BLOCK_LEN) ? DIV_STEPS : BLOCK_LEN;
    localparam int CNT_W     = $clog2(CNT_MAX);

    localparam logic [23:0] TPM_RESET = 24'd90317;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET     = 2'd1,
        OP_SET_NEW = 2'd2,
        OP_STOP    = 2'd3
    } opcode_t;

    typedef struct packed {
        logic apply;      // non-tick request taken
        logic mul;        // time * rate product
        logic div_init;   // load divider, latch tick count
        logic div_step;   // one quotient bit
        logic quot_load;  // latch block and sample step
        logic prep;       // start block, advance level
        logic emit_adv;   // sample taken downstream
    } dp_cmd_t;

    typedef struct packed {
        logic retarget_pending;
    } dp_status_t;

endpackage

### rtl/blrg_dp.sv
// ----------------------------------------------------------------------------
// blrg_dp
// Datapath: ramp state, tick-count multiply, bit-serial step divider and
// sample accumulator.
// ----------------------------------------------------------------------------
module blrg_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  blrg_pkg::dp_cmd_t   cmd,
    output blrg_pkg::dp_status_t status,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_data,
    input  logic [1:0]          opcode,
    input  logic signed [31:0]  target_value,
    input  logic [15:0]         ramp_time_ms,
    output logic signed [31:0]  sample,
    output logic signed [31:0]  current_value
);
    import blrg_pkg::*;

    logic [23:0]        tpm_reg, tpm_next;
    logic signed [31:0] target_reg, target_next;
    logic signed [31:0] current_reg, current_next;
    logic [15:0]        pending_reg, pending_next;
    logic [23:0]        ticks_reg, ticks_next;
    logic               retarget_reg, retarget_next;
    logic signed [31:0] block_step_reg, block_step_next;
    logic signed [31:0] sample_step_reg, sample_step_next;

    logic [39:0]        prod_reg, prod_next;
    logic [23:0]        divisor_reg, divisor_next;
    logic [23:0]        rem_reg, rem_next;
    logic [32:0]        quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic signed [39:0] acc_reg, acc_next;
    logic               ramp_reg, ramp_next;

    logic               set_hit;
    logic [23:0]        ticks_calc;
    logic [23:0]        ticks_eff;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [24:0]        rem_shift;
    logic               rem_ge;
    logic [24:0]        rem_sub;
    logic [32:0]        quo_neg;
    logic signed [31:0] step_calc;
    logic signed [39:0] level_sum;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign set_hit = (opcode == OP_SET) ||
                     ((opcode == OP_SET_NEW) && (target_reg != target_value));

    // product >> 16 of a 16x24 product always fits 24 bits
    assign ticks_calc = prod_reg[39:16];
    assign ticks_eff  = (ticks_calc == 24'd0) ? 24'd1 : ticks_calc;

    assign diff     = {target_reg[31], target_reg} - {current_reg[31], current_reg};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    assign rem_shift = {rem_reg, quo_reg[32]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign quo_neg   = -quo_reg;

    // Truncating quotient, saturated to 32-bit signed
    always_comb
    begin
        if (!neg_reg && (quo_reg > 33'h0_7FFF_FFFF)) begin
            step_calc = 32'sh7FFF_FFFF;
        end else if (neg_reg && (quo_reg > 33'h0_8000_0000)) begin
            step_calc = 32'sh8000_0000;
        end else if (neg_reg) begin
            step_calc = quo_neg[31:0];
        end else begin
            step_calc = quo_reg[31:0];
        end
    end

    assign level_sum = 40'(current_reg) + 40'(block_step_reg);

    always_comb
    begin
        tpm_next         = tpm_reg;
        target_next      = target_reg;
        current_next     = current_reg;
        pending_next     = pending_reg;
        ticks_next       = ticks_reg;
        retarget_next    = retarget_reg;
        block_step_next  = block_step_reg;
        sample_step_next = sample_step_reg;
        prod_next        = prod_reg;
        divisor_next     = divisor_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        neg_next         = neg_reg;
        acc_next         = acc_reg;
        ramp_next        = ramp_reg;

        if (cfg_we) begin
            tpm_next = cfg_data;
        end

        if (cmd.apply) begin
            if (set_hit) begin
                target_next = target_value;
                if (ramp_time_ms == 16'd0) begin
                    current_next  = target_value;
                    ticks_next    = 24'd0;
                    retarget_next = 1'b0;
                end else begin
                    retarget_next = 1'b1;
                    pending_next  = ramp_time_ms;
                end
            end else if (opcode == OP_STOP) begin
                target_next   = current_reg;
                ticks_next    = 24'd0;
                retarget_next = 1'b0;
            end
        end

        if (cmd.mul) begin
            prod_next = 40'(pending_reg) * 40'(tpm_reg);
        end

        if (cmd.div_init) begin
            ticks_next    = ticks_eff;
            divisor_next  = ticks_eff;
            retarget_next = 1'b0;
            rem_next      = 24'd0;
            quo_next      = diff_mag;
            neg_next      = diff[32];
        end

        if (cmd.div_step) begin
            rem_next = rem_ge ? rem_sub[23:0] : rem_shift[23:0];
            quo_next = {quo_reg[31:0], rem_ge};
        end

        if (cmd.quot_load) begin
            block_step_next  = step_calc;
            sample_step_next = step_calc >>> BLOCK_SHIFT;
        end

        if (cmd.prep) begin
            if (ticks_reg != 24'd0) begin
                acc_next     = 40'(current_reg);
                current_next = sat32(level_sum);
                ticks_next   = ticks_reg - 24'd1;
                ramp_next    = 1'b1;
            end else begin
                acc_next     = 40'(target_reg);
                current_next = target_reg;
                ramp_next    = 1'b0;
            end
        end

        // hold the target flat when no ramp is running
        if (cmd.emit_adv && ramp_reg) begin
            acc_next = acc_reg + 40'(sample_step_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tpm_reg         <= TPM_RESET;
            target_reg      <= '0;
            current_reg     <= '0;
            pending_reg     <= '0;
            ticks_reg       <= '0;
            retarget_reg    <= 1'b0;
            block_step_reg  <= '0;
            sample_step_reg <= '0;
        end else begin
            tpm_reg         <= tpm_next;
            target_reg      <= target_next;
            current_reg     <= current_next;
            pending_reg     <= pending_next;
            ticks_reg       <= ticks_next;
            retarget_reg    <= retarget_next;
            block_step_reg  <= block_step_next;
            sample_step_reg <= sample_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        acc_reg     <= acc_next;
        ramp_reg    <= ramp_next;
    end

    assign status.retarget_pending = retarget_reg;
    assign sample                  = sat32(acc_reg);
    assign current_value           = current_reg;

endmodule

### rtl/blrg_ctrl.sv
// ----------------------------------------------------------------------------
// blrg_ctrl
// Controller: request decode, retarget sequencing and block emission count.
// ----------------------------------------------------------------------------
module blrg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 last_in_block,
    output blrg_pkg::dp_cmd_t    cmd,
    input  blrg_pkg::dp_status_t status
);
    import blrg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_DIV,
        S_QUOT,
        S_PREP,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             tick_take;
    logic             cnt_last_div;
    logic             cnt_last_emit;

    assign tick_take     = (state_reg == S_IDLE) && in_valid && (opcode == OP_TICK);
    assign cnt_last_div  = cnt_reg == CNT_W'(DIV_STEPS - 1);
    assign cnt_last_emit = cnt_reg == CNT_W'(BLOCK_LEN - 1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                cmd.apply = in_valid && (opcode != OP_TICK);
                if (tick_take) begin
                    cnt_next = '0;
                    if (status.retarget_pending) begin
                        cmd.mul    = 1'b1;
                        state_next = S_INIT;
                    end else begin
                        state_next = S_PREP;
                    end
                end
            end
            S_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last_div) begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT:
            begin
                cmd.quot_load = 1'b1;
                state_next    = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_stall) begin
                    cmd.emit_adv = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_last_emit) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall      = state_reg != S_IDLE;
    assign out_valid     = state_reg == S_EMIT;
    assign last_in_block = (state_reg == S_EMIT) && cnt_last_emit;

endmodule

### rtl/block_linear_ramp_generator.sv
// ----------------------------------------------------------------------------
// block_linear_ramp_generator
// Block-rate linear ramp generator for audio parameters, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall) carries opcode, target_value and
//   ramp_time_ms. Set, set-if-new and stop are applied on acceptance and
//   produce no output. A tick emits BLOCK_LEN samples on the result channel
//   (out_valid/out_stall), one per cycle while out_stall is low, last_in_block
//   marking the final one; current_value is the level after the tick on every
//   sample of the block. Plain tick: a prep state, then the samples; the next
//   request is taken the cycle after the last sample leaves. The first tick
//   after a timed set first runs a divider load, the bit-serial step divider
//   (one quotient bit per cycle) and a latch of the block and sample step;
//   the time x rate multiply shares the tick's acceptance cycle.
//   in_stall is high from a tick's acceptance until its block is delivered.
//   A stalled receiver freezes the sample stream, nothing is dropped.
//   ticks_per_ms (cfg_valid/cfg_ready, always ready) must be written while
//   idle; the block does not enforce it. Reset zeroes the ramp state, loads
//   the default rate; requests are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module block_linear_ramp_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] target_value,
    input  logic [15:0]        ramp_time_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sample,
    output logic               last_in_block,
    output logic signed [31:0] current_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        ticks_per_ms
);
    import blrg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    blrg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .last_in_block (last_in_block),
        .cmd           (cmd),
        .status        (status)
    );

    blrg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (ticks_per_ms),
        .opcode        (opcode),
        .target_value  (target_value),
        .ramp_time_ms  (ramp_time_ms),
        .sample        (sample),
        .current_value (current_value)
    );

    // no request taken while a block is on the output
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while a block is being emitted");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_in_block |-> out_valid)
        else $error("last_in_block without a valid sample");

    // reopen the request side right after the block ends
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_in_block) |=> !in_stall)
        else $error("request side not released after block");

    // level is fixed for the whole block
    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_in_block) |=> $stable(current_value))
        else $error("current_value changed within a block");

endmodule

### dv/blrg_checker.sv
// ----------------------------------------------------------------------------
// blrg_checker
// Watches the request, result and rate-write channels of the ramp generator.
// Keeps its own copy of the ramp state, predicts the block of samples for
// each accepted tick and compares every delivered sample field by field.
// ----------------------------------------------------------------------------
module blrg_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] target_value,
    input  logic [15:0]        ramp_time_ms,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] sample,
    input  logic               last_in_block,
    input  logic signed [31:0] current_value,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [23:0]        ticks_per_ms,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import blrg_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic signed [31:0] level;
    } ramp_sample_t;

    ramp_sample_t       ramp_samples_q[$];

    logic [23:0]        rate;
    logic signed [31:0] tgt_lvl;
    logic signed [31:0] cur_lvl;
    logic [15:0]        pend_ms;
    logic [23:0]        ticks_left;
    logic               retarget;
    logic signed [31:0] blk_step;
    logic signed [31:0] smp_step;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic retarget_to(input logic signed [31:0] tgt, input logic [15:0] ms);
        tgt_lvl = tgt;
        if (ms == 16'd0)
        begin
            cur_lvl    = tgt;
            ticks_left = '0;
            retarget   = 1'b0;
        end
        else
        begin
            retarget = 1'b1;
            pend_ms  = ms;
        end
    endtask

    task automatic apply_request(input opcode_t op, input logic signed [31:0] tgt,
                                 input logic [15:0] ms);
        longint             steps;
        longint             acc;
        logic signed [31:0] vals [BLOCK_LEN];
        ramp_sample_t       e;
        case (op)
            OP_SET:
                retarget_to(tgt, ms);
            OP_SET_NEW:
                if (tgt_lvl != tgt)
                    retarget_to(tgt, ms);
            OP_STOP:
            begin
                tgt_lvl    = cur_lvl;
                ticks_left = '0;
                retarget   = 1'b0;
            end
            default:
            begin
                if (retarget)
                begin
                    steps = (longint'(pend_ms) * longint'(rate)) >> 16;
                    if (steps > 64'd16777215)
                        steps = 64'd16777215;
                    if (steps == 0)
                        steps = 1;
                    ticks_left = steps[23:0];
                    blk_step   = clamp32((longint'(tgt_lvl) - longint'(cur_lvl)) / steps);
                    smp_step   = blk_step >>> BLOCK_SHIFT;
                    retarget   = 1'b0;
                end
                if (ticks_left != '0)
                begin
                    acc = cur_lvl;
                    for (int k = 0; k < BLOCK_LEN; k++)
                    begin
                        vals[k] = clamp32(acc);
                        acc     = acc + smp_step;
                    end
                    cur_lvl    = clamp32(longint'(cur_lvl) + longint'(blk_step));
                    ticks_left = ticks_left - 24'd1;
                end
                else
                begin
                    // ramp done or never started: snap to the target
                    cur_lvl = tgt_lvl;
                    for (int k = 0; k < BLOCK_LEN; k++)
                        vals[k] = tgt_lvl;
                end
                for (int k = 0; k < BLOCK_LEN; k++)
                begin
                    e.value = vals[k];
                    e.last  = (k == BLOCK_LEN - 1);
                    e.level = cur_lvl;
                    ramp_samples_q.push_back(e);
                end
            end
        endcase
    endtask

    task automatic check_sample();
        ramp_sample_t e;
        if (ramp_samples_q.size() == 0)
        begin
            if (mismatches < 10)
                $display("ERROR %0t: sample=%0d last=%0b level=%0d %s",
                         $time, sample, last_in_block, current_value,
                         "with no tick pending");
            mismatches++;
        end
        else
        begin
            e = ramp_samples_q.pop_front();
            if (sample !== e.value || last_in_block !== e.last || current_value !== e.level)
            begin
                if (mismatches < 10)
                    $display({"ERROR %0t: expected sample=%0d last=%0b level=%0d, ",
                              "got sample=%0d last=%0b level=%0d"},
                             $time, e.value, e.last, e.level,
                             sample, last_in_block, current_value);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate       = TPM_RESET;
            tgt_lvl    = '0;
            cur_lvl    = '0;
            pend_ms    = '0;
            ticks_left = '0;
            retarget   = 1'b0;
            blk_step   = '0;
            smp_step   = '0;
            mismatches = 0;
            ramp_samples_q.delete();
            outstanding = 0;
        end
        else
        begin
            // compare first so a sample is never matched against this edge's tick
            if (out_valid && !out_stall)
                check_sample();
            if (cfg_valid && cfg_ready)
                rate = ticks_per_ms;
            if (in_valid && !in_stall)
                apply_request(opcode_t'(opcode), target_value, ramp_time_ms);
            outstanding = ramp_samples_q.size();
        end
    end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the ramp generator with a directed sequence of set, set-if-new, stop
// and tick requests, then random phases at several rate settings, some with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blrg_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic signed [31:0] target_value;
    logic [15:0]        ramp_time_ms;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] sample;
    logic               last_in_block;
    logic signed [31:0] current_value;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [23:0]        ticks_per_ms;

    int                 mismatches;
    int                 outstanding;
    bit                 pace_on;
    logic signed [31:0] last_target;

    block_linear_ramp_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .target_value  (target_value),
        .ramp_time_ms  (ramp_time_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .last_in_block (last_in_block),
        .current_value (current_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .ticks_per_ms  (ticks_per_ms)
    );

    blrg_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .target_value  (target_value),
        .ramp_time_ms  (ramp_time_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .last_in_block (last_in_block),
        .current_value (current_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .ticks_per_ms  (ticks_per_ms),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("block_linear_ramp_generator test failed");
        $finish;
    end

    // Result side: hold off for a random number of cycles, then take one sample
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = pace_on ? $urandom_range(0, 19) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    task automatic send(input opcode_t op, input logic [31:0] tgt, input logic [15:0] ms);
        int gap;
        gap = pace_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        target_value <= tgt;
        ramp_time_ms <= ms;
        if (op == OP_SET || op == OP_SET_NEW)
            last_target = tgt;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        @(negedge clk);
    endtask

    task automatic write_rate(input logic [23:0] v);
        cfg_valid    <= 1'b1;
        ticks_per_ms <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Let every expected sample arrive, then give a set or stop time to settle
    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_target();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'($signed($urandom_range(0, 4095)) - 2048) <<< 12;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            send(OP_TICK, $urandom(), 16'($urandom()));
        else if (r < 75)
            send(OP_SET, pick_target(), pick_time());
        else if (r < 85)
            send(OP_SET_NEW, ($urandom_range(0, 1) == 0) ? last_target : pick_target(),
                 pick_time());
        else if (r < 93)
            send(OP_STOP, $urandom(), 16'($urandom()));
        else
            send(OP_SET, pick_target(), 16'd0);
    endtask

    task automatic run_phase(input logic [23:0] v, input int count, input bit paced);
        write_rate(v);
        pace_on = paced;
        repeat (count) random_request();
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_TICK;
        target_value = '0;
        ramp_time_ms = '0;
        cfg_valid    = 1'b0;
        ticks_per_ms = TPM_RESET;
        pace_on      = 1'b1;
        last_target  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset rate, jumps, one-tick ramp, snap at end, ignored and
        // taken set-if-new, stop mid-ramp, retarget during a running ramp
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_SET,     32'h7FFFFFFF, 16'd0);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_SET,     32'h80000000, 16'd1);
        send(OP_TICK,    32'hFFFFFFFF, 16'hFFFF);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_SET,     32'h00010000, 16'd3);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_SET_NEW, 32'h00010000, 16'd5);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_SET,     32'hFFFF0000, 16'hFFFF);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_STOP,    32'h0,        16'd0);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_SET_NEW, 32'h12345678, 16'd2);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_SET,     32'hABCDEF01, 16'd4);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_TICK,    32'h0,        16'd0);
        send(OP_SET_NEW, 32'h0,        16'd0);
        send(OP_TICK,    32'h0,        16'd0);
        drain();

        run_phase(24'hFFFFFF, 32, 1'b1);
        run_phase(24'h000000, 30, 1'b0);
        run_phase(24'h010000, 32, 1'b1);
        run_phase(24'($urandom()), 32, 1'b0);
        run_phase(TPM_RESET, 32, 1'b1);

        if (mismatches == 0 && outstanding == 0)
            $display("block_linear_ramp_generator test passed");
        else
            $display("block_linear_ramp_generator test failed");
        $finish;
    end

endmodule
